>>> design/lrq_pkg.sv
// ----------------------------------------------------------------------------
// lrq_pkg
// Shared types and codes for the landmark table radius query block.
// ----------------------------------------------------------------------------
package lrq_pkg;

    // width of the position fields on the ports
    localparam int POS_W = 32;

    // command codes of an input word
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_code_t;

    // input word
    typedef struct packed {
        cmd_code_t          cmd;
        logic [15:0]        landmark_id;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic [30:0]        search_radius;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [15:0]        result_id;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic               found;
        logic               last;
        logic               status;
    } out_word_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEARCH,
        ST_APPLY,
        ST_EMIT,
        ST_Q_SETUP,
        ST_Q_DIFF,
        ST_Q_SQ,
        ST_Q_CMP,
        ST_Q_END
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;       // take the input word, reset scan index
        logic idx_inc;     // advance scan index
        logic clear_tbl;   // empty the table
        logic apply;       // insert or lookup at the search point
        logic load_r2;     // square the radius
        logic load_diff;   // absolute differences of current slot
        logic load_sq;     // squares of the differences
        logic take_match;  // hold current slot if it matches
        logic push_held;   // move held word to output register
        logic held_last;   // last flag for the pushed word
        logic set_empty;   // held word becomes the all-zero closing word
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      search_go;
        logic      idx_end;
        logic      match;
        logic      have_held;
        logic      out_free;
    } dp_status_t;

endpackage

>>> design/lrq_ctrl.sv
// ----------------------------------------------------------------------------
// lrq_ctrl
// Sequencer: accepts words, steps the sorted search and the radius scan.
// ----------------------------------------------------------------------------
module lrq_ctrl
    import lrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.latch = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                unique case (status.cmd) inside
                    CMD_CLEAR: state_next = ST_CLEAR;
                    CMD_QUERY: state_next = ST_Q_SETUP;
                    CMD_INSERT, CMD_LOOKUP:
                    begin
                        if (status.search_go)
                        begin
                            dp_cmd.idx_inc = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_APPLY;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_CLEAR:
            begin
                dp_cmd.clear_tbl = 1'b1;
                dp_cmd.set_empty = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_APPLY:
            begin
                dp_cmd.apply = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    dp_cmd.push_held = 1'b1;
                    dp_cmd.held_last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_Q_SETUP:
            begin
                dp_cmd.load_r2 = 1'b1;
                state_next     = ST_Q_DIFF;
            end
            ST_Q_DIFF:
            begin
                if (status.idx_end)
                begin
                    state_next = ST_Q_END;
                end
                else
                begin
                    dp_cmd.load_diff = 1'b1;
                    state_next       = ST_Q_SQ;
                end
            end
            ST_Q_SQ:
            begin
                dp_cmd.load_sq = 1'b1;
                state_next     = ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                // a new match flushes the previous one, which needs the output free
                if (!(status.match && status.have_held) || status.out_free)
                begin
                    dp_cmd.take_match = 1'b1;
                    dp_cmd.push_held  = status.match && status.have_held;
                    dp_cmd.idx_inc    = 1'b1;
                    state_next        = ST_Q_DIFF;
                end
            end
            ST_Q_END:
            begin
                if (status.have_held)
                begin
                    if (status.out_free)
                    begin
                        dp_cmd.push_held = 1'b1;
                        dp_cmd.held_last = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    dp_cmd.set_empty = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> design/lrq_dp.sv
// ----------------------------------------------------------------------------
// lrq_dp
// Datapath: sorted landmark table, squared distance unit, output register.
// ----------------------------------------------------------------------------
module lrq_dp
    import lrq_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_BITS  = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_word_t   in_word,
    input  dp_cmd_t    dp_cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word
);

    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CB = COORD_BITS;

    // input word and scan state
    in_word_t        in_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   count_reg;

    // table storage, slots 0..count-1 sorted by id
    logic [15:0]        key_reg [TABLE_DEPTH];
    logic signed [CB-1:0] x_reg [TABLE_DEPTH];
    logic signed [CB-1:0] y_reg [TABLE_DEPTH];

    // distance unit registers
    logic [2*CB-3:0] r2_reg;
    logic [CB-1:0]   ax_reg;
    logic [CB-1:0]   ay_reg;
    logic [2*CB-1:0] sx_reg;
    logic [2*CB-1:0] sy_reg;

    // held result and output register
    out_word_t held_reg;
    logic      have_held_reg;
    out_word_t out_reg;
    logic      out_valid_reg;

    logic [AW-1:0]        rd_a;
    logic [15:0]          rd_key;
    logic signed [CB-1:0] rd_x;
    logic signed [CB-1:0] rd_y;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic                 in_range;
    logic                 hit;
    logic                 ins_hit;
    logic                 ins_new;
    logic                 full;
    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic [2*CB:0]        dist2;
    logic                 match;
    logic                 out_free;

    // read of the slot under the scan index
    assign rd_a     = idx_reg[AW-1:0];
    assign rd_key   = key_reg[rd_a];
    assign rd_x     = x_reg[rd_a];
    assign rd_y     = y_reg[rd_a];
    assign px       = in_reg.pos_x_in[CB-1:0];
    assign py       = in_reg.pos_y_in[CB-1:0];
    assign in_range = idx_reg < count_reg;
    assign hit      = in_range && (rd_key == in_reg.landmark_id);
    assign full     = count_reg == IW'(TABLE_DEPTH);
    assign ins_hit  = dp_cmd.apply && (in_reg.cmd == CMD_INSERT) && hit;
    assign ins_new  = dp_cmd.apply && (in_reg.cmd == CMD_INSERT) && !hit && !full;

    // differences at one bit above coordinate width
    assign dx    = (CB+1)'(rd_x) - (CB+1)'(px);
    assign dy    = (CB+1)'(rd_y) - (CB+1)'(py);
    assign dist2 = (2*CB+1)'(sx_reg) + (2*CB+1)'(sy_reg);
    assign match = dist2 <= (2*CB+1)'(r2_reg);

    assign out_free = !out_valid_reg || out_ready;

    // status to controller
    always_comb
    begin
        status.cmd       = in_reg.cmd;
        status.search_go = in_range && (rd_key < in_reg.landmark_id);
        status.idx_end   = idx_reg == count_reg;
        status.match     = match;
        status.have_held = have_held_reg;
        status.out_free  = out_free;
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch)
        begin
            in_reg <= in_word;
        end
    end

    // scan index and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (dp_cmd.latch)
            begin
                idx_reg <= '0;
            end
            else if (dp_cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (dp_cmd.clear_tbl)
            begin
                count_reg <= '0;
            end
            else if (ins_new)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // per-slot write: replace, place new entry, or shift up by one
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++)
    begin : g_slot
        if (gi == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if ((ins_hit || ins_new) && idx_reg == IW'(gi))
                begin
                    key_reg[gi] <= in_reg.landmark_id;
                    x_reg[gi]   <= px;
                    y_reg[gi]   <= py;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if ((ins_hit || ins_new) && idx_reg == IW'(gi))
                begin
                    key_reg[gi] <= in_reg.landmark_id;
                    x_reg[gi]   <= px;
                    y_reg[gi]   <= py;
                end
                else if (ins_new && IW'(gi) > idx_reg && IW'(gi) <= count_reg)
                begin
                    key_reg[gi] <= key_reg[gi-1];
                    x_reg[gi]   <= x_reg[gi-1];
                    y_reg[gi]   <= y_reg[gi-1];
                end
            end
        end
    end

    // squared distance steps
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_r2)
        begin
            r2_reg <= in_reg.search_radius[CB-2:0] * in_reg.search_radius[CB-2:0];
        end
        if (dp_cmd.load_diff)
        begin
            ax_reg <= dx[CB] ? CB'(-dx) : CB'(dx);
            ay_reg <= dy[CB] ? CB'(-dy) : CB'(dy);
        end
        if (dp_cmd.load_sq)
        begin
            sx_reg <= ax_reg * ax_reg;
            sy_reg <= ay_reg * ay_reg;
        end
    end

    // held result word
    always_ff @(posedge clk)
    begin
        if (dp_cmd.set_empty)
        begin
            held_reg <= '0;
        end
        else if (dp_cmd.apply)
        begin
            held_reg.result_id <= in_reg.landmark_id;
            held_reg.pos_x_out <= '0;
            held_reg.pos_y_out <= '0;
            held_reg.found     <= 1'b0;
            held_reg.last      <= 1'b1;
            held_reg.status    <= 1'b0;
            if (in_reg.cmd == CMD_LOOKUP && hit)
            begin
                held_reg.pos_x_out <= POS_W'(rd_x);
                held_reg.pos_y_out <= POS_W'(rd_y);
                held_reg.found     <= 1'b1;
            end
            if (in_reg.cmd == CMD_INSERT && !hit && full)
            begin
                held_reg.status <= 1'b1;
            end
        end
        else if (dp_cmd.take_match && match)
        begin
            held_reg.result_id <= rd_key;
            held_reg.pos_x_out <= POS_W'(rd_x);
            held_reg.pos_y_out <= POS_W'(rd_y);
            held_reg.found     <= 1'b1;
            held_reg.last      <= 1'b0;
            held_reg.status    <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_held_reg <= 1'b0;
        end
        else if (dp_cmd.latch)
        begin
            have_held_reg <= 1'b0;
        end
        else if (dp_cmd.take_match && match)
        begin
            have_held_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.push_held)
        begin
            out_reg      <= held_reg;
            out_reg.last <= dp_cmd.held_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.push_held)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push_held |-> out_free)
        else $error("output word overwritten before taken");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.clear_tbl |=> count_reg == '0)
        else $error("table not empty after clear");

    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ins_new |=> count_reg == $past(count_reg) + 1'b1)
        else $error("new insert did not grow table");
`endif

endmodule

>>> design/landmark_table_radius_query.sv
// ----------------------------------------------------------------------------
// landmark_table_radius_query
// Sorted landmark table with insert, lookup, clear and exact radius query.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    in_word  (in_word_t)
//   output    out_valid / out_ready  out_word (out_word_t)
//
// Input is taken only in the idle state; the output register lets the next
// word in while the previous result waits. Insert and lookup find their
// slot by a linear scan of the sorted table, then apply and emit. A radius
// query squares the radius, then each entry passes a difference, square
// and compare step; nothing matching gives an all-zero closing word.
// Reset empties the table; output stalls hold the scan at the next match.
// ----------------------------------------------------------------------------
module landmark_table_radius_query
    import lrq_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_BITS  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    // sequencer
    lrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    // table and arithmetic
    lrq_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .dp_cmd    (dp_cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

>>> test/landmark_table_radius_query_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// landmark_table_radius_query_checker
// Watches both channels of the landmark table. Each accepted input word is run
// through a local copy of the sorted table to queue the result words it must
// give; each accepted output word is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module landmark_table_radius_query_checker
    import lrq_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    output int        error_count,
    output int        pending_count
);

    // local copy of the table
    logic [15:0]        tbl_key [TABLE_DEPTH];
    logic signed [31:0] tbl_x [TABLE_DEPTH];
    logic signed [31:0] tbl_y [TABLE_DEPTH];
    int                 tbl_count;

    out_word_t expected_words[$];

    assign pending_count = expected_words.size();

    // one line per mismatch, counted
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic out_word_t make_word(logic [15:0] id, logic signed [31:0] x,
                                            logic signed [31:0] y, logic fnd,
                                            logic lst, logic sts);
        out_word_t w;
        w.result_id = id;
        w.pos_x_out = x;
        w.pos_y_out = y;
        w.found     = fnd;
        w.last      = lst;
        w.status    = sts;
        return w;
    endfunction

    // append one expected word at the tail
    task automatic queue_word(input out_word_t w);
        expected_words = {expected_words, w};
    endtask

    // apply one command to the table and queue its result words
    task automatic predict_table_command(input in_word_t w);
        int                 pos;
        int                 n;
        logic [63:0]        r2;
        logic [63:0]        ax;
        logic [63:0]        ay;
        logic [64:0]        dist2;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        out_word_t          hit;
        pos = 0;
        n = 0;
        if (w.cmd == CMD_CLEAR)
        begin
            tbl_count = 0;
            queue_word(make_word(16'd0, 32'sd0, 32'sd0, 1'b0, 1'b1, 1'b0));
            return;
        end
        while (pos < tbl_count && tbl_key[pos] < w.landmark_id)
            pos++;
        case (w.cmd)
            CMD_INSERT:
            begin
                if (pos < tbl_count && tbl_key[pos] == w.landmark_id)
                begin
                    tbl_x[pos] = w.pos_x_in;
                    tbl_y[pos] = w.pos_y_in;
                end
                else if (tbl_count >= TABLE_DEPTH)
                begin
                    queue_word(make_word(w.landmark_id, 32'sd0, 32'sd0, 1'b0, 1'b1, 1'b1));
                    return;
                end
                else
                begin
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_key[i] = tbl_key[i - 1];
                        tbl_x[i]   = tbl_x[i - 1];
                        tbl_y[i]   = tbl_y[i - 1];
                    end
                    tbl_key[pos] = w.landmark_id;
                    tbl_x[pos]   = w.pos_x_in;
                    tbl_y[pos]   = w.pos_y_in;
                    tbl_count++;
                end
                queue_word(make_word(w.landmark_id, 32'sd0, 32'sd0, 1'b0, 1'b1, 1'b0));
            end
            CMD_LOOKUP:
            begin
                if (pos < tbl_count && tbl_key[pos] == w.landmark_id)
                    queue_word(make_word(w.landmark_id, tbl_x[pos], tbl_y[pos],
                                         1'b1, 1'b1, 1'b0));
                else
                    queue_word(make_word(w.landmark_id, 32'sd0, 32'sd0, 1'b0, 1'b1, 1'b0));
            end
            default:
            begin
                // exact squared distance, overflow past 64 bits counts as outside
                r2 = {33'd0, w.search_radius} * {33'd0, w.search_radius};
                for (int i = 0; i < tbl_count; i++)
                begin
                    dx = 33'(tbl_x[i]) - 33'(w.pos_x_in);
                    dy = 33'(tbl_y[i]) - 33'(w.pos_y_in);
                    ax = dx < 0 ? 64'(-dx) : 64'(dx);
                    ay = dy < 0 ? 64'(-dy) : 64'(dy);
                    dist2 = 65'(ax * ax) + 65'(ay * ay);
                    if (!dist2[64] && dist2[63:0] <= r2)
                    begin
                        queue_word(make_word(tbl_key[i], tbl_x[i], tbl_y[i],
                                             1'b1, 1'b0, 1'b0));
                        n++;
                    end
                end
                if (n == 0)
                    queue_word(make_word(16'd0, 32'sd0, 32'sd0, 1'b0, 1'b1, 1'b0));
                else
                begin
                    hit = expected_words[expected_words.size() - 1];
                    hit.last = 1'b1;
                    expected_words[expected_words.size() - 1] = hit;
                end
            end
        endcase
    endtask

    // compare one result word with the oldest expectation
    task automatic compare_result(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0)
        begin
            report("unexpected word", 64'(got), 64'd0);
            return;
        end
        want = expected_words.pop_front();
        if (got.result_id !== want.result_id)
            report("result_id", 64'(got.result_id), 64'(want.result_id));
        if (got.pos_x_out !== want.pos_x_out)
            report("pos_x_out", 64'(got.pos_x_out), 64'(want.pos_x_out));
        if (got.pos_y_out !== want.pos_y_out)
            report("pos_y_out", 64'(got.pos_y_out), 64'(want.pos_y_out));
        if (got.found !== want.found)
            report("found", 64'(got.found), 64'(want.found));
        if (got.last !== want.last)
            report("last", 64'(got.last), 64'(want.last));
        if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
    endtask

    // watch both channels at the rising edge
    initial
    begin
        error_count = 0;
        tbl_count   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid && out_ready)
                    compare_result(out_word);
                if (in_valid && in_ready)
                    predict_table_command(in_word);
            end
        end
    end

endmodule

>>> test/landmark_table_radius_query_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// landmark_table_radius_query_test
// Drives command words into the landmark table with random gaps and output
// stalls: a directed opening over the special cases that fills, overflows
// and replaces, then random sequences that insert, look up and query the table.
// ----------------------------------------------------------------------------
module landmark_table_radius_query_test;
    import lrq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int STALL_LIMIT = 4000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;
    int        error_count;
    int        pending_count;
    int        quiet_cycles;
    logic [15:0] used_ids[$];

    landmark_table_radius_query #(.TABLE_DEPTH(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    landmark_table_radius_query_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // send one word after a random gap, hold it until taken
    task automatic send_word(input cmd_code_t c, input logic [15:0] id,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [30:0] r);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        in_word.cmd           <= c;
        in_word.landmark_id   <= id;
        in_word.pos_x_in      <= x;
        in_word.pos_y_in      <= y;
        in_word.search_radius <= r;
        in_valid              <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random coordinate, mostly near the origin, sometimes anywhere
    function automatic logic [31:0] random_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    // random id, often one already used
    function automatic logic [15:0] random_id();
        if (used_ids.size() > 0 && $urandom_range(0, 2) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return 16'($urandom());
    endfunction

    // receiver stall pattern
    initial
    begin
        int hold;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold)
                    @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // watchdog on cycles with nothing accepted
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("landmark_table_radius_query test failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] id;
        int          kind;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, replace, miss, full table
        send_word(CMD_QUERY, 16'h0000, 32'h0, 32'h0, 31'h7fffffff);
        send_word(CMD_LOOKUP, 16'hffff, 32'h0, 32'h0, 31'h0);
        send_word(CMD_INSERT, 16'hffff, 32'h7fffffff, 32'h80000000, 31'h0);
        send_word(CMD_INSERT, 16'h0000, 32'h80000000, 32'h7fffffff, 31'h0);
        send_word(CMD_INSERT, 16'h8000, 32'h0, 32'h0, 31'h0);
        send_word(CMD_QUERY, 16'h1234, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        send_word(CMD_QUERY, 16'h0, 32'h0, 32'h0, 31'h0);
        send_word(CMD_QUERY, 16'h0, 32'h0, 32'h0, 31'h7fffffff);
        send_word(CMD_INSERT, 16'h8000, 32'h00010000, 32'hffff0000, 31'h0);
        send_word(CMD_LOOKUP, 16'h8000, 32'h0, 32'h0, 31'h0);
        send_word(CMD_LOOKUP, 16'h0000, 32'h0, 32'h0, 31'h0);
        send_word(CMD_LOOKUP, 16'h0001, 32'h0, 32'h0, 31'h0);
        send_word(CMD_CLEAR, 16'hffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
        send_word(CMD_LOOKUP, 16'hffff, 32'h0, 32'h0, 31'h0);
        for (int i = 0; i < DEPTH; i++)
            send_word(CMD_INSERT, 16'(DEPTH - i) * 16'd3, 32'(i) << 16, 32'(-i) << 16, 31'h0);
        send_word(CMD_INSERT, 16'd1, 32'h0, 32'h0, 31'h0);
        send_word(CMD_INSERT, 16'd3, 32'h5555aaaa, 32'haaaa5555, 31'h0);
        send_word(CMD_QUERY, 16'h0, 32'h0, 32'h0, 31'h7fffffff);
        send_word(CMD_QUERY, 16'h0, 32'h00080000, 32'hfff80000, 31'h00030000);
        in_valid <= 1'b0;

        // let every expected word drain before going on
        wait (pending_count == 0);
        repeat (120)
            @(negedge clk);
        send_word(CMD_CLEAR, 16'h0, 32'h0, 32'h0, 31'h0);

        // random phase: inserts with lookups, queries and rare clears mixed in
        for (int n = 0; n < 60; n++)
        begin
            kind = $urandom_range(0, 99);
            id   = random_id();
            if (kind < 2)
            begin
                send_word(CMD_CLEAR, 16'($urandom()), $urandom(), $urandom(), 31'($urandom()));
                used_ids.delete();
            end
            else if (kind < 50)
            begin
                used_ids.push_front(id);
                send_word(CMD_INSERT, id, random_coord(), random_coord(), 31'($urandom()));
            end
            else if (kind < 72)
                send_word(CMD_LOOKUP, id, $urandom(), $urandom(), 31'($urandom()));
            else
                send_word(CMD_QUERY, 16'($urandom()), random_coord(), random_coord(),
                          ($urandom_range(0, 4) == 0) ? 31'($urandom())
                                                      : 31'($urandom_range(0, 1 << 21)));
        end
        in_valid <= 1'b0;

        wait (pending_count == 0);
        repeat (200)
            @(negedge clk);
        if (error_count == 0)
            $display("landmark_table_radius_query test passed");
        else
            $display("landmark_table_radius_query test failed");
        $finish;
    end

endmodule
